// ===== design/dns_answer_address_extractor_top_assert.svh =====
// Assertion macros for the DNS answer address extractor.
// Every check is clocked on aclk; the plain form is also gated off during reset.
`ifndef DNS_ANSWER_ADDRESS_EXTRACTOR_TOP_ASSERT_SVH
`define DNS_ANSWER_ADDRESS_EXTRACTOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define DAE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define DAE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define DAE_ASSERT(lbl, prop, msg)
`define DAE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/dae_pkg.sv =====
package dae_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned IP_W      = 32;
    localparam int unsigned ID_W      = 16;
    localparam int unsigned M_TDATA_W = 40;

    localparam logic [ID_W-1:0] QUERY_ID_RESET = 16'h1234;

    // parse phases
    localparam logic [3:0] PH_HEADER = 4'd0;
    localparam logic [3:0] PH_QNAME  = 4'd1;
    localparam logic [3:0] PH_QPTR   = 4'd2;
    localparam logic [3:0] PH_QTAIL  = 4'd3;
    localparam logic [3:0] PH_ANAME  = 4'd4;
    localparam logic [3:0] PH_APTR   = 4'd5;
    localparam logic [3:0] PH_AFIXED = 4'd6;
    localparam logic [3:0] PH_RDATA  = 4'd7;
    localparam logic [3:0] PH_DONE   = 4'd8;
    localparam logic [3:0] PH_DRAIN  = 4'd9;

    // field offsets within phases
    localparam logic [3:0] OFS_ID_LO   = 4'd1;
    localparam logic [3:0] OFS_FLAG_LO = 4'd3;
    localparam logic [3:0] OFS_QD_LO   = 4'd5;
    localparam logic [3:0] OFS_AN_LO   = 4'd7;
    localparam logic [3:0] OFS_HDR_END = 4'd11;
    localparam logic [3:0] OFS_TYPE_LO = 4'd1;
    localparam logic [3:0] OFS_FIX_END = 4'd9;
    localparam logic [3:0] OFS_QT_END  = 4'd3;
    localparam logic [3:0] OFS_RD_END  = 4'd3;

    localparam logic [15:0] TYPE_A      = 16'd1;
    localparam logic [15:0] RDLEN_IPV4  = 16'd4;
    localparam logic [1:0]  PTR_TAG     = 2'b11;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ID       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTRESP  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOANSWER = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOTA     = 3'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              last_byte;
    } dae_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IP_W-1:0]     ip_address;
    } dae_result_t;

endpackage

// ===== design/dns_answer_address_extractor_top.sv =====
// DNS response parser: one payload byte per word, one status and IPv4 address word out per packet.
// Throughput: one byte per clock, with no gaps between packets; a last byte waits
// only while the result register holds a word the sink has not taken yet.
// Result path: the last byte waits in the input register; its result word is then
// loaded into the result register, whose valid flag drives m_tvalid.
// Reset: synchronous, active-low aresetn; query_id to 0x1234, parser to header phase.
`include "dns_answer_address_extractor_top_assert.svh"

module dns_answer_address_extractor_top (
    input  logic        aclk,
    input  logic        aresetn,
    // config: query_id
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // last_byte
    // one result word per packet
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [2:0] status, [34:3] ip_address, [39:35] zero
);
    import dae_pkg::*;

    logic [ID_W-1:0] query_id_reg;
    dae_item_t       s_item;
    dae_item_t       item;
    logic            item_valid;
    logic            fire;
    logic            load;
    logic            space;
    dae_result_t     result;
    logic [3:0]      phase;

    // Transaction ID register; the user must write it only between packets (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_id_reg <= QUERY_ID_RESET;
        end else if (cfg_we) begin
            query_id_reg <= cfg_wdata;
        end
    end

    assign s_item.rx_byte   = s_tdata;
    assign s_item.last_byte = s_tlast;

    // A mid-packet byte never waits; the last byte waits only for room in the
    // result register, which frees up in the same cycle the sink takes a word.
    assign fire = item_valid && (!item.last_byte || space);
    assign load = fire && item.last_byte;

    dae_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    // Header checks, name skipping, answer fields and address assembly.
    dae_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .item     (item),
        .query_id (query_id_reg),
        .result   (result),
        .phase    (phase)
    );

    dae_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .result   (result),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A packet end always restarts the parser at the header.
    `DAE_ASSERT(a_last_restarts, load |=> phase == PH_HEADER, "parser not restarted after last byte")
    // Every packet end leaves a word waiting at the output.
    `DAE_ASSERT(a_result_follows, load |=> m_tvalid, "no result after last byte")
    // The address is only shown with a resolved status.
    `DAE_ASSERT(a_ip_only_resolved, m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[34:3] == 32'd0, "address on failed result")
    // Nothing is consumed from an empty input register.
    `DAE_ASSERT_ALWAYS(a_fire_needs_item, fire |-> item_valid, "parse step without a word")
endmodule

// ===== design/dae_in_stage.sv =====
module dae_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  dae_pkg::dae_item_t  s_item,
    input  logic                take,
    output logic                item_valid,
    output dae_pkg::dae_item_t  item
);
    import dae_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    dae_item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

// ===== design/dae_parser.sv =====
module dae_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  dae_pkg::dae_item_t   item,
    input  logic [15:0]          query_id,
    output dae_pkg::dae_result_t result,
    output logic [3:0]           phase
);
    import dae_pkg::*;

    logic [3:0]          phase_reg,   phase_next;
    logic [3:0]          offset_reg,  offset_next;
    logic [15:0]         hword_reg,   hword_next;
    logic [15:0]         qleft_reg,   qleft_next;
    logic [7:0]          lleft_reg,   lleft_next;
    logic [15:0]         atype_reg,   atype_next;
    logic [31:0]         addr_reg,    addr_next;
    logic [STATUS_W-1:0] outcome_reg, outcome_next;
    logic [15:0]         hw_shift;
    logic [STATUS_W-1:0] fail_code;
    logic [7:0]          b;

    assign b        = item.rx_byte;
    assign hw_shift = {hword_reg[7:0], b};

    always_comb begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        hword_next   = hword_reg;
        qleft_next   = qleft_reg;
        lleft_next   = lleft_reg;
        atype_next   = atype_reg;
        addr_next    = addr_reg;
        outcome_next = outcome_reg;
        fail_code    = ST_OK;
        case (phase_reg)
            PH_HEADER: begin
                hword_next = hw_shift;
                if (offset_reg == OFS_ID_LO && hw_shift != query_id) begin
                    fail_code = ST_ID;
                end
                if (offset_reg == OFS_FLAG_LO && !hw_shift[15]) begin
                    fail_code = ST_NOTRESP;
                end
                if (offset_reg == OFS_QD_LO) begin
                    qleft_next = hw_shift;
                end
                if (offset_reg == OFS_AN_LO && hw_shift == 16'd0) begin
                    fail_code = ST_NOANSWER;
                end
                if (fail_code != ST_OK && outcome_reg == ST_OK) begin
                    outcome_next = fail_code;
                end
                if (offset_reg >= OFS_HDR_END) begin
                    if (outcome_next != ST_OK) begin
                        phase_next = PH_DRAIN;
                    end else begin
                        phase_next  = (qleft_reg == 16'd0) ? PH_ANAME : PH_QNAME;
                        offset_next = 4'd0;
                        lleft_next  = 8'd0;
                    end
                end else begin
                    offset_next = offset_reg + 4'd1;
                end
            end
            PH_QNAME, PH_ANAME: begin
                if (lleft_reg != 8'd0) begin
                    lleft_next = lleft_reg - 8'd1;
                end else if (b == 8'd0) begin
                    phase_next  = (phase_reg == PH_QNAME) ? PH_QTAIL : PH_AFIXED;
                    offset_next = 4'd0;
                end else if (b[7:6] == PTR_TAG) begin
                    phase_next = (phase_reg == PH_QNAME) ? PH_QPTR : PH_APTR;
                end else begin
                    lleft_next = b;
                end
            end
            PH_QPTR: begin
                phase_next  = PH_QTAIL;
                offset_next = 4'd0;
            end
            PH_APTR: begin
                phase_next  = PH_AFIXED;
                offset_next = 4'd0;
            end
            PH_QTAIL: begin
                if (offset_reg >= OFS_QT_END) begin
                    qleft_next  = qleft_reg - 16'd1;
                    phase_next  = (qleft_reg == 16'd1) ? PH_ANAME : PH_QNAME;
                    offset_next = 4'd0;
                    lleft_next  = 8'd0;
                end else begin
                    offset_next = offset_reg + 4'd1;
                end
            end
            PH_AFIXED: begin
                hword_next = hw_shift;
                if (offset_reg == OFS_TYPE_LO) begin
                    atype_next = hw_shift;
                end
                if (offset_reg >= OFS_FIX_END) begin
                    if (atype_reg == TYPE_A && hw_shift == RDLEN_IPV4) begin
                        phase_next  = PH_RDATA;
                        offset_next = 4'd0;
                        addr_next   = 32'd0;
                    end else begin
                        if (outcome_reg == ST_OK) begin
                            outcome_next = ST_NOTA;
                        end
                        phase_next = PH_DRAIN;
                    end
                end else begin
                    offset_next = offset_reg + 4'd1;
                end
            end
            PH_RDATA: begin
                addr_next = {addr_reg[23:0], b};
                if (offset_reg >= OFS_RD_END) begin
                    phase_next = PH_DONE;
                end else begin
                    offset_next = offset_reg + 4'd1;
                end
            end
            PH_DONE, PH_DRAIN: begin
            end
            default: begin
                phase_next = PH_DRAIN;
            end
        endcase
    end

    // status as seen after this word is consumed
    always_comb begin
        result.ip_address = '0;
        case (phase_next)
            PH_HEADER: result.status = ST_SHORT;
            PH_DONE: begin
                result.status     = ST_OK;
                result.ip_address = addr_next;
            end
            PH_DRAIN: result.status = outcome_next;
            default:  result.status = ST_TRUNC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && item.last_byte)) begin
            phase_reg   <= PH_HEADER;
            offset_reg  <= '0;
            hword_reg   <= '0;
            qleft_reg   <= '0;
            lleft_reg   <= '0;
            atype_reg   <= '0;
            addr_reg    <= '0;
            outcome_reg <= ST_OK;
        end else if (fire) begin
            phase_reg   <= phase_next;
            offset_reg  <= offset_next;
            hword_reg   <= hword_next;
            qleft_reg   <= qleft_next;
            lleft_reg   <= lleft_next;
            atype_reg   <= atype_next;
            addr_reg    <= addr_next;
            outcome_reg <= outcome_next;
        end
    end

    assign phase = phase_reg;
endmodule

// ===== design/dae_out_stage.sv =====
module dae_out_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  dae_pkg::dae_result_t            result,
    output logic                            space,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dae_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dae_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    dae_result_t result_reg;

    assign space      = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W - IP_W - STATUS_W){1'b0}},
                       result_reg.ip_address, result_reg.status};
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dae_pkg::*;

    // Run length and limits
    localparam int CYCLE_LIMIT   = 1_000_000; // far above the slowest legal run
    localparam int BYTES_PER_SET = 240;       // at least 1440 random words over six query_id settings
    localparam int DRAIN_CYCLES  = 24;        // quiet time to watch for stray result words
    localparam int CFG_SETTLE    = 4;

    // ------------------------------------------------------------------
    // Scoreboard: carries its own copy of the parser and of query_id,
    // turns each accepted byte word into zero or one expected answers,
    // and compares result words in order.
    // ------------------------------------------------------------------
    class dns_answer_scoreboard;
        logic [15:0] query_id;
        logic [3:0]  phase;
        logic [3:0]  field_ofs;
        logic [15:0] shift_word;
        logic [15:0] questions_left;
        logic [7:0]  label_left;
        logic [15:0] rr_type;
        logic [15:0] rr_len;
        logic [31:0] addr_acc;
        logic [2:0]  first_fault;

        dae_result_t expected_answers[$];
        int errors;

        function new();
            query_id = QUERY_ID_RESET;
            errors   = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            phase          = PH_HEADER;
            field_ofs      = '0;
            shift_word     = '0;
            questions_left = '0;
            label_left     = '0;
            rr_type        = '0;
            rr_len         = '0;
            addr_acc       = '0;
            first_fault    = ST_OK;
        endfunction

        function void flag_fault(logic [2:0] code);
            if (first_fault == ST_OK) first_fault = code;
        endfunction

        // one name byte; 1 on the terminating null, is_ptr on a pointer tag
        function bit name_step(logic [7:0] b, output bit is_ptr);
            is_ptr = 1'b0;
            if (label_left != 0) begin
                label_left = label_left - 8'd1;
                return 1'b0;
            end
            if (b == 8'd0) return 1'b1;
            if (b[7:6] == PTR_TAG) begin
                is_ptr = 1'b1;
                return 1'b0;
            end
            label_left = b;
            return 1'b0;
        endfunction

        function void next_question();
            phase      = (questions_left == 0) ? PH_ANAME : PH_QNAME;
            field_ofs  = '0;
            label_left = '0;
        endfunction

        function void parse_byte(logic [7:0] b);
            bit is_ptr;
            case (phase)
                PH_HEADER: begin
                    shift_word = {shift_word[7:0], b};
                    if (field_ofs == OFS_ID_LO && shift_word != query_id) flag_fault(ST_ID);
                    if (field_ofs == OFS_FLAG_LO && !shift_word[15]) flag_fault(ST_NOTRESP);
                    if (field_ofs == OFS_QD_LO) questions_left = shift_word;
                    if (field_ofs == OFS_AN_LO && shift_word == 0) flag_fault(ST_NOANSWER);
                    if (field_ofs >= OFS_HDR_END) begin
                        if (first_fault != ST_OK) phase = PH_DRAIN;
                        else next_question();
                    end else begin
                        field_ofs = field_ofs + 4'd1;
                    end
                end
                PH_QNAME: begin
                    if (name_step(b, is_ptr)) begin
                        phase     = PH_QTAIL;
                        field_ofs = '0;
                    end else if (is_ptr) begin
                        phase = PH_QPTR;
                    end
                end
                PH_QPTR: begin
                    phase     = PH_QTAIL;
                    field_ofs = '0;
                end
                PH_QTAIL: begin
                    if (field_ofs >= OFS_QT_END) begin
                        questions_left = questions_left - 16'd1;
                        next_question();
                    end else begin
                        field_ofs = field_ofs + 4'd1;
                    end
                end
                PH_ANAME: begin
                    if (name_step(b, is_ptr)) begin
                        phase     = PH_AFIXED;
                        field_ofs = '0;
                    end else if (is_ptr) begin
                        phase = PH_APTR;
                    end
                end
                PH_APTR: begin
                    phase     = PH_AFIXED;
                    field_ofs = '0;
                end
                PH_AFIXED: begin
                    shift_word = {shift_word[7:0], b};
                    if (field_ofs == OFS_TYPE_LO) rr_type = shift_word;
                    if (field_ofs >= OFS_FIX_END) begin
                        rr_len = shift_word;
                        if (rr_type == TYPE_A && rr_len == RDLEN_IPV4) begin
                            phase     = PH_RDATA;
                            field_ofs = '0;
                            addr_acc  = '0;
                        end else begin
                            flag_fault(ST_NOTA);
                            phase = PH_DRAIN;
                        end
                    end else begin
                        field_ofs = field_ofs + 4'd1;
                    end
                end
                PH_RDATA: begin
                    addr_acc = {addr_acc[23:0], b};
                    if (field_ofs >= OFS_RD_END) phase = PH_DONE;
                    else field_ofs = field_ofs + 4'd1;
                end
                PH_DONE: ;
                default: phase = PH_DRAIN;
            endcase
        endfunction

        // accepted input word
        function void note_byte(logic [7:0] b, logic last);
            dae_result_t ans;
            parse_byte(b);
            if (!last) return;
            ans.ip_address = '0;
            if (phase == PH_HEADER) begin
                ans.status = ST_SHORT;
            end else if (phase == PH_DONE) begin
                ans.status     = ST_OK;
                ans.ip_address = addr_acc;
            end else if (phase == PH_DRAIN) begin
                ans.status = first_fault;
            end else begin
                ans.status = ST_TRUNC;
            end
            expected_answers.push_back(ans);
            clear_parser();
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH %s", $realtime, msg);
        endtask

        // accepted result word: [2:0] status, [34:3] ip_address, [39:35] zero
        task check_result(logic [39:0] word);
            dae_result_t want;
            if (expected_answers.size() == 0) begin
                report($sformatf("result word %h with no answer pending", word));
                return;
            end
            want = expected_answers.pop_front();
            if (word[2:0] !== want.status)
                report($sformatf("status %0d, want %0d", word[2:0], want.status));
            if (word[34:3] !== want.ip_address)
                report($sformatf("ip_address %h, want %h", word[34:3], want.ip_address));
            if (word[39:35] !== 5'd0)
                report($sformatf("pad bits %b not zero", word[39:35]));
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] rx_byte
    logic        s_tlast   = 1'b0; // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // [2:0] status, [34:3] ip_address, [39:35] zero

    dns_answer_address_extractor_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    dns_answer_scoreboard sb = new();

    logic [7:0] pkt[$];    // packet being built, one byte per word
    int bytes_sent  = 0;
    int cycle_count = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("dns_answer_address_extractor_top regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side. Handshake is judged on pre-edge values; tready is
    // then redrawn. Stalls come in bursts (busy mode) with quiet stretches
    // between them.
    // ------------------------------------------------------------------
    int rx_stall_left = 0;
    bit rx_busy       = 1'b1;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if ($urandom_range(0, 199) == 0) rx_busy = !rx_busy;
        if (rx_stall_left > 0) begin
            rx_stall_left = rx_stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (rx_busy && $urandom_range(0, 3) == 0)
                rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(1, 3);
        end
    end

    // ------------------------------------------------------------------
    // Send side
    // ------------------------------------------------------------------
    // Drive one word and hold it until taken. tvalid is left high so a
    // back-to-back word gets only one assignment in that time step.
    task automatic send_word(logic [7:0] b, logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic idle_for(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // mostly no gap or a short one, occasionally a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_packet();
        int gap_mode;
        gap_mode = $urandom_range(0, 3);  // 0: packet goes out back to back
        foreach (pkt[i]) begin
            send_word(pkt[i], i == pkt.size() - 1);
            if (gap_mode != 0) idle_for(pick_gap());
        end
    endtask

    // query_id only changes with the parser idle: all answers back, then
    // a settle wait before the write.
    task automatic write_query_id(logic [15:0] v);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (CFG_SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        sb.query_id = v;
    endtask

    // ------------------------------------------------------------------
    // Packet builders
    // ------------------------------------------------------------------
    function automatic void push16(logic [15:0] v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endfunction

    // Name as labels + null, labels + pointer, or a bare pointer.
    // Rare long labels use length bytes with top bits 01 or 10.
    function automatic void add_name();
        int kind;
        int len;
        kind = $urandom_range(0, 2);
        if (kind != 0) begin
            repeat ($urandom_range(0, 3)) begin
                len = ($urandom_range(0, 14) == 0) ? $urandom_range(64, 191)
                                                   : $urandom_range(1, 9);
                pkt.push_back(8'(len));
                repeat (len) pkt.push_back(8'($urandom));
            end
        end
        if (kind == 1) begin
            pkt.push_back(8'h00);
        end else begin
            pkt.push_back({PTR_TAG, 6'($urandom)});
            pkt.push_back(8'($urandom));
        end
    endfunction

    function automatic void build_response(bit bad_id, bit bad_resp, bit no_ans, bit bad_rec);
        int          qd;
        int          which;
        logic [15:0] id;
        logic [15:0] flags;
        logic [15:0] an;
        logic [15:0] rtype;
        logic [15:0] rlen;
        pkt.delete();
        id       = bad_id ? (sb.query_id ^ 16'($urandom_range(1, 65535))) : sb.query_id;
        flags    = 16'($urandom);
        flags[15] = !bad_resp;
        an       = no_ans ? 16'd0 :
                   ($urandom_range(0, 1) ? 16'd1 : 16'($urandom_range(1, 65535)));
        qd       = $urandom_range(0, 2);
        push16(id);
        push16(flags);
        push16(16'(qd));
        push16(an);
        push16(16'($urandom));
        push16(16'($urandom));
        repeat (qd) begin
            add_name();
            repeat (4) pkt.push_back(8'($urandom));
        end
        add_name();
        rtype = TYPE_A;
        rlen  = RDLEN_IPV4;
        if (bad_rec) begin
            which = $urandom_range(0, 2);
            if (which != 1) rtype = 16'($urandom);
            if (which != 0) rlen  = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 8))
                                                          : 16'($urandom);
        end
        push16(rtype);
        push16(16'($urandom));                      // class
        push16(16'($urandom));                      // TTL
        push16(16'($urandom));
        push16(rlen);
        repeat (bad_rec ? $urandom_range(0, 6) : 4) pkt.push_back(8'($urandom));
        // further records or padding after the address are ignored
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
    endfunction

    function automatic void cut_to(int n);
        while (pkt.size() > n) void'(pkt.pop_back());
    endfunction

    // Mostly well-formed answers with random content; the rest is broken
    // headers, wrong records, early ends and plain noise.
    function automatic void random_packet();
        int r;
        r = $urandom_range(0, 99);
        if (r < 52) begin
            build_response(0, 0, 0, 0);
        end else if (r < 60) begin
            build_response(0, 0, 0, 1);
        end else if (r < 74) begin
            build_response(0, 0, 0, $urandom_range(0, 3) == 0);
            // question count replaced with a random value
            if ($urandom_range(0, 2) == 0) begin
                pkt[4] = 8'($urandom);
                pkt[5] = 8'($urandom);
            end
            cut_to($urandom_range(12, pkt.size()));
        end else if (r < 79) begin
            build_response(1, 0, 0, 0);
        end else if (r < 83) begin
            build_response(0, 1, 0, 0);
        end else if (r < 87) begin
            build_response(0, 0, 1, 0);
        end else if (r < 90) begin
            build_response($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1), 0);
        end else if (r < 95) begin
            // ends inside the header, possibly after a failed check
            build_response($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1), 0);
            cut_to($urandom_range(1, 11));
        end else begin
            pkt.delete();
            repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
        end
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] id_plan[6];
        int target;
        id_plan = '{QUERY_ID_RESET, 16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom),
                    QUERY_ID_RESET};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, with query_id at its reset value.
        // single null byte with tlast: short header
        pkt = {8'h00};
        send_packet();
        // every header check fails at once: the id fault wins
        pkt = {8'h12, 8'h35, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_packet();
        // no questions, pointer-only answer name (no null after it), A record
        pkt = {8'h12, 8'h34, 8'h81, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01,
               8'h00, 8'h00, 8'h00, 8'h00, 8'hC0, 8'h0C, 8'h00, 8'h01,
               8'h00, 8'h01, 8'h00, 8'h00, 8'h0E, 8'h10, 8'h00, 8'h04,
               8'hFF, 8'h00, 8'h80, 8'h01};
        send_packet();

        // Random part, one query_id setting per set; the config write
        // also forces the sender to wait for every answer to come back.
        for (int set = 0; set < 6; set++) begin
            if (set != 0) write_query_id(id_plan[set]);
            target = bytes_sent + BYTES_PER_SET;
            while (bytes_sent < target) begin
                random_packet();
                send_packet();
                if ($urandom_range(0, 2) == 0) idle_for(pick_gap());
            end
        end
        s_tvalid <= 1'b0;

        // wait out outstanding answers, then watch for stray result words
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("dns_answer_address_extractor_top regression: pass");
        end else begin
            $display("dns_answer_address_extractor_top regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/dae_pkg.sv
design/dae_in_stage.sv
design/dae_parser.sv
design/dae_out_stage.sv
design/dns_answer_address_extractor_top.sv
tb/tb_top.sv
